// ===== sv/pshba_pkg.sv =====
package pshba_pkg;

  localparam int HOSTS      = 64;
  localparam int TOTAL_BITS = 40;
  localparam int USED_W     = $clog2(HOSTS + 1);
  localparam int DELTA_W    = 18;

  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam int          IP_HDR_BYTES    = 20;
  localparam int          MIN_FRAME_BYTES = 30;
  localparam int          POS_SAT         = 30;

  localparam logic signed [TOTAL_BITS-1:0] TOT_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOT_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  // Result status codes
  localparam logic [2:0] ST_NOMATCH = 3'd0;
  localparam logic [2:0] ST_KNOWN   = 3'd1;
  localparam logic [2:0] ST_NEW     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;

  // Request token walking the cell row.  st starts at ST_FULL for a
  // countable frame; the cell that finds or inserts the source rewrites it.
  typedef struct packed {
    logic [2:0]                   st;
    logic [31:0]                  src;
    logic signed [DELTA_W-1:0]    delta;
    logic signed [TOTAL_BITS-1:0] host;
    logic                         have;
    logic [31:0]                  best_ip;
    logic signed [TOTAL_BITS-1:0] best;
  } req_t;

endpackage

// ===== sv/pshba_cell.sv =====
module pshba_cell
  import pshba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic req_vld_i,
  input  req_t req_i,
  output logic req_vld_o,
  output req_t req_o
);

  logic                         used_r;
  logic [31:0]                  addr_r;
  logic signed [TOTAL_BITS-1:0] total_r;
  logic                         vld_r;
  req_t                         req_r;

  logic                         hit;
  logic                         ins;
  logic                         cur_used;
  logic                         take;
  logic signed [TOTAL_BITS:0]   sum_ext;
  logic signed [TOTAL_BITS-1:0] sat;
  logic signed [TOTAL_BITS-1:0] delta_ext;
  logic signed [TOTAL_BITS-1:0] new_total;
  logic [31:0]                  cur_addr;
  req_t                         req_nxt;

  always_comb begin
    hit       = req_vld_i && used_r && (req_i.st == ST_FULL) && (addr_r == req_i.src);
    ins       = req_vld_i && !used_r && (req_i.st == ST_FULL);
    cur_used  = used_r | ins;
    delta_ext = {{(TOTAL_BITS-DELTA_W){req_i.delta[DELTA_W-1]}}, req_i.delta};
    sum_ext   = {total_r[TOTAL_BITS-1], total_r} +
                {{(TOTAL_BITS+1-DELTA_W){req_i.delta[DELTA_W-1]}}, req_i.delta};
    // overflow when the two top bits disagree
    if (sum_ext[TOTAL_BITS] != sum_ext[TOTAL_BITS-1]) begin
      sat = sum_ext[TOTAL_BITS] ? TOT_MIN : TOT_MAX;
    end else begin
      sat = sum_ext[TOTAL_BITS-1:0];
    end
    new_total = hit ? sat : (ins ? delta_ext : total_r);
    cur_addr  = ins ? req_i.src : addr_r;
    // strict greater keeps the earliest entry on ties
    take      = req_vld_i && cur_used && (!req_i.have || (new_total > req_i.best));

    req_nxt = req_i;
    if (hit) begin
      req_nxt.st   = ST_KNOWN;
      req_nxt.host = sat;
    end
    if (ins) begin
      req_nxt.st   = ST_NEW;
      req_nxt.host = delta_ext;
    end
    if (take) begin
      req_nxt.have    = 1'b1;
      req_nxt.best    = new_total;
      req_nxt.best_ip = cur_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      used_r <= cur_used;
      vld_r  <= req_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    if (hit || ins) begin
      total_r <= new_total;
    end
    if (ins) begin
      addr_r <= req_i.src;
    end
  end

  assign req_vld_o = vld_r;
  assign req_o     = req_r;

endmodule

// ===== sv/per_source_host_byte_accounting_top.sv =====
// Per-source host byte accounting.
//
// in_*  : one frame byte per beat, wire order from the destination address;
//         in_tlast marks the final byte of a frame.
// out_* : one result beat per frame (launched by its last byte).
// cfg_* : writes the matching frame type (reset value 0x0800); always ready.
//
// Bytes other than the last are taken one per cycle while no frame is
// in flight. The last byte launches a request token down a row of HOSTS
// cells, one cell per cycle; each cell holds one table entry and does the
// lookup, the saturating update, the in-order insert into the first free
// cell and one step of the top-source scan. in_tready stays low from the
// last byte until the result has been loaded into the output register.
//
// Reset empties the table, clears the byte captures and restores the type.
// A finished result waits in the output register while out_tready is low;
// the next frame is taken meanwhile, and its token holds at the row's end
// until the output register frees.
module per_source_host_byte_accounting_top
  import pshba_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] source_ip, [71:32] host_bytes, [103:72] top_ip,
  // [143:104] top_bytes, [150:144] hosts_in_use, [151] zero
  output logic [151:0] out_tdata,
  output logic [2:0]   out_tuser,  // [2:0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // match_ethertype
);

  // byte positions of captured header fields
  localparam logic [4:0] POS_TYPE_HI = 5'd12;
  localparam logic [4:0] POS_TYPE_LO = 5'd13;
  localparam logic [4:0] POS_LEN_HI  = 5'd16;
  localparam logic [4:0] POS_LEN_LO  = 5'd17;
  localparam logic [4:0] POS_SRC_0   = 5'd26;
  localparam logic [4:0] POS_SRC_1   = 5'd27;
  localparam logic [4:0] POS_SRC_2   = 5'd28;
  localparam logic [4:0] POS_SRC_3   = 5'd29;

  logic [15:0]  match_r;
  logic [4:0]   pos_r,  pos_nxt;
  logic [15:0]  type_r, type_nxt;
  logic [15:0]  len_r,  len_nxt;
  logic [31:0]  src_r,  src_nxt;
  logic         inflight_r;
  logic         launch_vld_r;
  req_t         launch_r;
  req_t         launch_nxt;
  logic         tail_vld_r;
  req_t         tail_r;
  logic [USED_W-1:0] used_r;
  logic         out_vld_r;
  logic [151:0] out_data_r;
  logic [2:0]   out_user_r;

  logic         in_acc;
  logic         out_load;
  logic         chain_vld [HOSTS+1];
  req_t         chain_req [HOSTS+1];

  assign cfg_ready = 1'b1;
  assign in_tready = !inflight_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = tail_vld_r && (!out_vld_r || out_tready);

  // capture with the current byte folded in
  always_comb begin
    type_nxt = type_r;
    len_nxt  = len_r;
    src_nxt  = src_r;
    case (pos_r)
      POS_TYPE_HI: type_nxt[15:8] = in_tdata;
      POS_TYPE_LO: type_nxt[7:0]  = in_tdata;
      POS_LEN_HI:  len_nxt[15:8]  = in_tdata;
      POS_LEN_LO:  len_nxt[7:0]   = in_tdata;
      POS_SRC_0:   src_nxt[31:24] = in_tdata;
      POS_SRC_1:   src_nxt[23:16] = in_tdata;
      POS_SRC_2:   src_nxt[15:8]  = in_tdata;
      POS_SRC_3:   src_nxt[7:0]   = in_tdata;
      default: ;
    endcase
    pos_nxt = (pos_r < 5'(POS_SAT)) ? pos_r + 5'd1 : pos_r;

    launch_nxt         = '0;
    launch_nxt.delta   = $signed({2'b00, len_nxt}) - DELTA_W'(IP_HDR_BYTES);
    if ((6'(pos_r) + 6'd1) < 6'(MIN_FRAME_BYTES)) begin
      launch_nxt.st = ST_SHORT;
    end else if (type_nxt != match_r) begin
      launch_nxt.st = ST_NOMATCH;
    end else begin
      launch_nxt.st  = ST_FULL;
      launch_nxt.src = src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r      <= ETYPE_IPV4;
      pos_r        <= '0;
      type_r       <= '0;
      len_r        <= '0;
      src_r        <= '0;
      inflight_r   <= 1'b0;
      launch_vld_r <= 1'b0;
      tail_vld_r   <= 1'b0;
      used_r       <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        match_r <= cfg_data;
      end
      launch_vld_r <= in_acc && in_tlast;
      if (in_acc) begin
        if (in_tlast) begin
          pos_r      <= '0;
          type_r     <= '0;
          len_r      <= '0;
          src_r      <= '0;
          inflight_r <= 1'b1;
        end else begin
          pos_r  <= pos_nxt;
          type_r <= type_nxt;
          len_r  <= len_nxt;
          src_r  <= src_nxt;
        end
      end
      if (chain_vld[HOSTS]) begin
        tail_vld_r <= 1'b1;
        if (chain_req[HOSTS].st == ST_NEW) begin
          used_r <= used_r + USED_W'(1);
        end
      end else if (out_load) begin
        tail_vld_r <= 1'b0;
      end
      if (out_load) begin
        inflight_r <= 1'b0;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      launch_r <= launch_nxt;
    end
    if (chain_vld[HOSTS]) begin
      tail_r <= chain_req[HOSTS];
    end
    if (out_load) begin
      out_user_r <= tail_r.st;
      out_data_r <= {1'b0, used_r, tail_r.best, tail_r.best_ip, tail_r.host, tail_r.src};
    end
  end

  assign chain_vld[0] = launch_vld_r;
  assign chain_req[0] = launch_r;

  for (genvar g = 0; g < HOSTS; g++) begin : g_cell
    pshba_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req_vld_i (chain_vld[g]),
      .req_i     (chain_req[g]),
      .req_vld_o (chain_vld[g+1]),
      .req_o     (chain_req[g+1])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
